>>> rtl/osat_pkg.sv
// Shared types, constants and the target test for the one-shot alarm timer.
// No dependencies; used by one_shot_alarm_timer_core.
package osat_pkg;

    localparam int unsigned TIME_BITS       = 32;
    localparam int unsigned HW_COUNTER_BITS = 16;
    localparam int unsigned MIN_LEAD_TICKS  = 5;
    localparam int unsigned FUNC_BITS       = 3;

    localparam logic [TIME_BITS-1:0] HALF_RANGE = 32'h7FFF_FFFF;
    localparam logic [TIME_BITS-1:0] MIN_LEAD   = TIME_BITS'(MIN_LEAD_TICKS);

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_TICK  = 3'd0,
        FUNC_LATCH = 3'd1,
        FUNC_START = 3'd2,
        FUNC_STOP  = 3'd3,
        FUNC_READ  = 3'd4
    } t_func;

    typedef struct packed {
        logic                       ok;      // target still ahead by enough ticks
        logic                       arm;     // target lies within one hardware span
        logic [HW_COUNTER_BITS-1:0] value;   // low bits of the target
    } t_load;

    // True when the distance fits inside one span of the hardware count.
    function automatic logic within_span(input logic [TIME_BITS-1:0] gap);
        return gap[TIME_BITS-1:HW_COUNTER_BITS] == '0;
    endfunction

    // Classifies a target against the current time.
    function automatic t_load load_target(input logic [TIME_BITS-1:0] target,
                                          input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] gap;
        logic [TIME_BITS-1:0] gap_m1;
        t_load                res;
        gap       = target - now;
        gap_m1    = gap - TIME_BITS'(1);
        res.ok    = (gap_m1 < HALF_RANGE) && (gap >= MIN_LEAD);
        res.arm   = res.ok && within_span(gap);
        res.value = target[HW_COUNTER_BITS-1:0];
        return res;
    endfunction

endpackage

>>> rtl/one_shot_alarm_timer_core.sv
// One-shot alarm timer on an extended 32-bit tick counter.
// Depends on osat_pkg (types, constants and the target test).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  command | in        | i_valid / o_stall    | i_func, i_timeout
//  result  | out       | o_valid / i_stall    | o_now_time, o_elapsed, o_alarm_active,
//          |           |                      | o_alarm_fired, o_fired_late,
//          |           |                      | o_compare_armed
//
// The timer state updates at the accepting edge and
// the result is held in an output register from the next cycle on.
// A new command transaction is taken in every cycle in which the result register is
// empty or is being emptied, so the sustained rate is one item per clock while i_stall stays low.
// o_stall rises only while a result sits in the output register and i_stall is high.
// Synchronous active-low reset clears the timer state and the result valid flag.
module one_shot_alarm_timer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [osat_pkg::FUNC_BITS-1:0]    i_func,
    input  logic [osat_pkg::TIME_BITS-1:0]    i_timeout,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [osat_pkg::TIME_BITS-1:0]    o_now_time,
    output logic [osat_pkg::TIME_BITS-1:0]    o_elapsed,
    output logic                              o_alarm_active,
    output logic                              o_alarm_fired,
    output logic                              o_fired_late,
    output logic                              o_compare_armed
);

    localparam int unsigned TB = osat_pkg::TIME_BITS;
    localparam int unsigned HB = osat_pkg::HW_COUNTER_BITS;

    // Timer state. The target (reference plus delay) is kept precomputed so that a
    // tick only needs the increment, subtracts from the target and the compares.
    logic [TB-1:0] r_tick_count,     n_tick_count;
    logic [TB-1:0] r_reference_time, n_reference_time;
    logic [TB-1:0] r_alarm_delay,    n_alarm_delay;
    logic [TB-1:0] r_target,         n_target;
    logic          r_running,        n_running;
    logic          r_pend_int,       n_pend_int;
    logic [HB-1:0] r_cmp_value,      n_cmp_value;
    logic          r_cmp_en,         n_cmp_en;

    // Result register.
    logic          r_out_valid;
    logic [TB-1:0] r_out_now;
    logic [TB-1:0] r_out_elapsed;
    logic          r_out_running;
    logic          r_out_fired;
    logic          r_out_late;
    logic          r_out_armed;

    logic          n_fired;
    logic          n_late;
    logic          accept;
    logic          tick_wrap;
    logic [TB-1:0] start_target;
    osat_pkg::t_load ovf_load;
    osat_pkg::t_load start_load;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_tick_count     = r_tick_count;
        n_reference_time = r_reference_time;
        n_alarm_delay    = r_alarm_delay;
        n_target         = r_target;
        n_running        = r_running;
        n_pend_int       = r_pend_int;
        n_cmp_value      = r_cmp_value;
        n_cmp_en         = r_cmp_en;
        n_fired          = 1'b0;
        n_late           = 1'b0;
        tick_wrap        = 1'b0;
        start_target     = r_reference_time + i_timeout;
        ovf_load         = osat_pkg::load_target(r_target, r_tick_count + TB'(1));
        start_load       = osat_pkg::load_target(start_target, r_tick_count);

        case (osat_pkg::t_func'(i_func))
            osat_pkg::FUNC_TICK: begin
                n_tick_count = r_tick_count + TB'(1);
                tick_wrap    = n_tick_count[HB-1:0] == '0;
                // On a wrap of the hardware count, a waiting alarm whose target now falls within
                // one span and is still ahead by enough ticks gets its compare armed.
                if (tick_wrap && r_pend_int && osat_pkg::within_span(r_target - n_tick_count)
                        && ovf_load.arm) begin
                    n_cmp_value = ovf_load.value;
                    n_cmp_en    = 1'b1;
                end
                if (n_cmp_en && (n_tick_count[HB-1:0] == n_cmp_value)) begin
                    n_cmp_en   = 1'b0;
                    n_running  = 1'b0;
                    n_pend_int = 1'b0;
                    n_fired    = 1'b1;
                end
            end
            osat_pkg::FUNC_LATCH: begin
                n_reference_time = r_tick_count;
                n_target         = r_tick_count + r_alarm_delay;
            end
            osat_pkg::FUNC_START: begin
                n_alarm_delay = i_timeout;
                n_target      = start_target;
                n_running     = 1'b1;
                n_pend_int    = 1'b1;
                if (start_load.arm) begin
                    n_cmp_value = start_load.value;
                    n_cmp_en    = 1'b1;
                end
                // Target already passed or too close: fire at once, leave the
                // compare as it was.
                if (!start_load.ok) begin
                    n_pend_int = 1'b0;
                    n_fired    = 1'b1;
                    n_late     = 1'b1;
                end
            end
            osat_pkg::FUNC_STOP: begin
                n_running = 1'b0;
            end
            default: begin
                // Read and the unused codes change nothing.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count     <= '0;
            r_reference_time <= '0;
            r_alarm_delay    <= '0;
            r_target         <= '0;
            r_running        <= 1'b0;
            r_pend_int       <= 1'b0;
            r_cmp_value      <= '0;
            r_cmp_en         <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_tick_count     <= n_tick_count;
                r_reference_time <= n_reference_time;
                r_alarm_delay    <= n_alarm_delay;
                r_target         <= n_target;
                r_running        <= n_running;
                r_pend_int       <= n_pend_int;
                r_cmp_value      <= n_cmp_value;
                r_cmp_en         <= n_cmp_en;
                r_out_valid      <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it loads on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_now     <= n_tick_count;
            r_out_elapsed <= n_tick_count - n_reference_time;
            r_out_running <= n_running;
            r_out_fired   <= n_fired;
            r_out_late    <= n_late;
            r_out_armed   <= n_cmp_en;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_now_time      = r_out_now;
    assign o_elapsed       = r_out_elapsed;
    assign o_alarm_active  = r_out_running;
    assign o_alarm_fired   = r_out_fired;
    assign o_fired_late    = r_out_late;
    assign o_compare_armed = r_out_armed;

`ifndef NO_ASSERTIONS
    // Stalling upstream only happens with a full result register.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid)
        else $error("stall raised with empty result register");

    // An accepted tick advances the time by exactly one.
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_func == osat_pkg::FUNC_TICK)
        |=> r_tick_count == $past(r_tick_count) + TB'(1))
        else $error("tick did not advance time by one");

    // A late fire is always a fire.
    a_late_is_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fired_late |-> o_alarm_fired)
        else $error("late flag without fire");

    // A compare match stops the alarm and disarms the compare.
    a_match_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_alarm_fired && !o_fired_late |-> !o_alarm_active && !o_compare_armed)
        else $error("compare fire left alarm running or armed");
`endif

endmodule
